// ----- sv/clcd_pkg.sv -----
// clcd_pkg: shared types and constants for the character lcd nibble interface
// request/result payload structs, settings struct, phase encoding, init commands
// no dependencies
`timescale 1ns / 1ps

package clcd_pkg;

   // width of each timing register
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   // settings register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_UP_WAIT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_NIBBLE_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE_PULSE_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NIBBLE_GAP_WAIT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMMAND_WAIT       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_WAIT          = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLEAR_EXTRA_WAIT   = 3'd6;

   // register reset values in ticks
   localparam logic [CSR_DATA_BITS-1:0] RST_POWER_UP_WAIT      = 16'd50000;
   localparam logic [CSR_DATA_BITS-1:0] RST_FIRST_NIBBLE_WAIT  = 16'd5000;
   localparam logic [CSR_DATA_BITS-1:0] RST_ENABLE_PULSE_TICKS = 16'd1;
   localparam logic [CSR_DATA_BITS-1:0] RST_NIBBLE_GAP_WAIT    = 16'd100;
   localparam logic [CSR_DATA_BITS-1:0] RST_COMMAND_WAIT       = 16'd2000;
   localparam logic [CSR_DATA_BITS-1:0] RST_DATA_WAIT          = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] RST_CLEAR_EXTRA_WAIT   = 16'd2000;

   // lcd command bytes
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

   // init nibbles sent in 8-bit mode before switching to 4-bit
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

   // init step codes
   localparam logic [3:0] STEP_LAST_NIBBLE = 4'd3;
   localparam logic [3:0] STEP_FIRST_CMD   = 4'd4;
   localparam logic [3:0] STEP_LAST_CMD    = 4'd7;
   localparam logic [3:0] STEP_DONE        = 4'd8;

   // request modes
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef enum logic [8:0] {
      PH_POWER      = 9'b000000001,
      PH_INIT_PULSE = 9'b000000010,
      PH_INIT_WAIT  = 9'b000000100,
      PH_HIGH_PULSE = 9'b000001000,
      PH_MID_GAP    = 9'b000010000,
      PH_LOW_PULSE  = 9'b000100000,
      PH_BYTE_WAIT  = 9'b001000000,
      PH_CLEAR_WAIT = 9'b010000000,
      PH_IDLE       = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic       reg_select;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       rs_pin;
      logic       enable_pin;
      logic [3:0] bus_nibble;
      logic       ready_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] power_up_wait;
      logic [CSR_DATA_BITS-1:0] first_nibble_wait;
      logic [CSR_DATA_BITS-1:0] enable_pulse_ticks;
      logic [CSR_DATA_BITS-1:0] nibble_gap_wait;
      logic [CSR_DATA_BITS-1:0] command_wait;
      logic [CSR_DATA_BITS-1:0] data_wait;
      logic [CSR_DATA_BITS-1:0] clear_extra_wait;
   } cfg_type;

   // init command sequence, indexed from 0
   function automatic logic [7:0] init_cmd(input logic [1:0] idx);
      logic [7:0] cmd;
      case (idx)
         2'd0: cmd = CMD_FUNCTION_SET;
         2'd1: cmd = CMD_DISPLAY_ON;
         2'd2: cmd = CMD_CLEAR;
         2'd3: cmd = CMD_ENTRY_MODE;
         default: cmd = CMD_FUNCTION_SET;
      endcase
      return cmd;
   endfunction

endpackage

// ----- sv/clcd_csr.sv -----
// clcd_csr: timing settings registers written through the plain write port
// depends on clcd_pkg
`timescale 1ns / 1ps

module clcd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [clcd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [clcd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output clcd_pkg::cfg_type                    cfg
);

   clcd_pkg::cfg_type cfg_ff;
   clcd_pkg::cfg_type cfg_in;

   // decode the register index, unused index leaves everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            clcd_pkg::CSR_POWER_UP_WAIT:      cfg_in.power_up_wait      = csr_wdata;
            clcd_pkg::CSR_FIRST_NIBBLE_WAIT:  cfg_in.first_nibble_wait  = csr_wdata;
            clcd_pkg::CSR_ENABLE_PULSE_TICKS: cfg_in.enable_pulse_ticks = csr_wdata;
            clcd_pkg::CSR_NIBBLE_GAP_WAIT:    cfg_in.nibble_gap_wait    = csr_wdata;
            clcd_pkg::CSR_COMMAND_WAIT:       cfg_in.command_wait       = csr_wdata;
            clcd_pkg::CSR_DATA_WAIT:          cfg_in.data_wait          = csr_wdata;
            clcd_pkg::CSR_CLEAR_EXTRA_WAIT:   cfg_in.clear_extra_wait   = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_wait      <= clcd_pkg::RST_POWER_UP_WAIT;
         cfg_ff.first_nibble_wait  <= clcd_pkg::RST_FIRST_NIBBLE_WAIT;
         cfg_ff.enable_pulse_ticks <= clcd_pkg::RST_ENABLE_PULSE_TICKS;
         cfg_ff.nibble_gap_wait    <= clcd_pkg::RST_NIBBLE_GAP_WAIT;
         cfg_ff.command_wait       <= clcd_pkg::RST_COMMAND_WAIT;
         cfg_ff.data_wait          <= clcd_pkg::RST_DATA_WAIT;
         cfg_ff.clear_extra_wait   <= clcd_pkg::RST_CLEAR_EXTRA_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/clcd_seq.sv -----
// clcd_seq: lcd bus sequencer, one request per step (tick or write)
// holds phase, init step, wait counter and pin levels; depends on clcd_pkg
`timescale 1ns / 1ps

module clcd_seq #(
   parameter int WAIT_COUNTER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  clcd_pkg::req_type    req,
   input  clcd_pkg::cfg_type    cfg,
   output clcd_pkg::rsp_type    rsp
);

   localparam int CB = (WAIT_COUNTER_BITS > clcd_pkg::CSR_DATA_BITS) ?
                       WAIT_COUNTER_BITS : clcd_pkg::CSR_DATA_BITS;
   localparam logic [WAIT_COUNTER_BITS-1:0] CNT_TOP = '1;
   localparam logic [CB-1:0] CNT_TOP_EXT = CB'(CNT_TOP);

   clcd_pkg::phase_type             phase_ff, phase_in;
   logic [3:0]                      step_ff, step_in;
   logic [WAIT_COUNTER_BITS-1:0]    cnt_ff, cnt_in, cnt_inc;
   logic [7:0]                      held_byte_ff, held_byte_in;
   logic                            held_sel_ff, held_sel_in;
   logic                            clear_ff, clear_in;
   logic                            rs_ff, rs_in;
   logic                            en_ff, en_in;
   logic [3:0]                      nib_ff, nib_in;

   logic [clcd_pkg::CSR_DATA_BITS-1:0] target;
   logic [CB-1:0]                   target_ext, target_clamp;
   logic                            hit;
   logic                            fin;
   logic                            go_byte;
   logic [7:0]                      go_b;
   logic                            go_sel;
   logic                            ready;
   logic                            rej;

   // target of the current timed phase
   always_comb begin
      case (phase_ff)
         clcd_pkg::PH_POWER:      target = cfg.power_up_wait;
         clcd_pkg::PH_INIT_PULSE: target = cfg.enable_pulse_ticks;
         clcd_pkg::PH_INIT_WAIT:  target = (step_ff == 4'd0) ? cfg.first_nibble_wait :
                                                               cfg.nibble_gap_wait;
         clcd_pkg::PH_HIGH_PULSE: target = cfg.enable_pulse_ticks;
         clcd_pkg::PH_MID_GAP:    target = cfg.nibble_gap_wait;
         clcd_pkg::PH_LOW_PULSE:  target = cfg.enable_pulse_ticks;
         clcd_pkg::PH_BYTE_WAIT:  target = held_sel_ff ? cfg.data_wait : cfg.command_wait;
         clcd_pkg::PH_CLEAR_WAIT: target = cfg.clear_extra_wait;
         default:                 target = '0;
      endcase
   end

   // saturating counter step and clamped compare
   always_comb begin
      cnt_inc      = (cnt_ff == CNT_TOP) ? cnt_ff : cnt_ff + 1'b1;
      target_ext   = CB'(target);
      target_clamp = (target_ext > CNT_TOP_EXT) ? CNT_TOP_EXT : target_ext;
      hit          = CB'(cnt_inc) >= target_clamp;
   end

   // next state for one request
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      clear_in     = clear_ff;
      rs_in        = rs_ff;
      en_in        = en_ff;
      nib_in       = nib_ff;
      fin          = 1'b0;
      go_byte      = 1'b0;
      go_b         = req.data_byte;
      go_sel       = req.reg_select;
      rej          = 1'b0;

      if (req.mode == clcd_pkg::MODE_WRITE) begin
         // writes are taken only when idle after init
         if (phase_ff == clcd_pkg::PH_IDLE) begin
            clear_in = !req.reg_select && (req.data_byte == clcd_pkg::CMD_CLEAR);
            go_byte  = 1'b1;
         end else begin
            rej = 1'b1;
         end
      end else if (phase_ff != clcd_pkg::PH_IDLE) begin
         cnt_in = hit ? '0 : cnt_inc;
         if (hit) begin
            case (phase_ff)
               clcd_pkg::PH_POWER: begin
                  step_in  = 4'd0;
                  rs_in    = 1'b0;
                  nib_in   = clcd_pkg::NIB_WAKE;
                  en_in    = 1'b1;
                  phase_in = clcd_pkg::PH_INIT_PULSE;
               end
               clcd_pkg::PH_INIT_PULSE: begin
                  en_in    = 1'b0;
                  phase_in = clcd_pkg::PH_INIT_WAIT;
               end
               clcd_pkg::PH_INIT_WAIT: begin
                  step_in = step_ff + 4'd1;
                  if (step_in < clcd_pkg::STEP_FIRST_CMD) begin
                     rs_in    = 1'b0;
                     nib_in   = (step_in == clcd_pkg::STEP_LAST_NIBBLE) ?
                                clcd_pkg::NIB_FOUR_BIT : clcd_pkg::NIB_WAKE;
                     en_in    = 1'b1;
                     phase_in = clcd_pkg::PH_INIT_PULSE;
                  end else begin
                     go_byte = 1'b1;
                     go_b    = clcd_pkg::init_cmd(2'd0);
                     go_sel  = 1'b0;
                  end
               end
               clcd_pkg::PH_HIGH_PULSE: begin
                  en_in    = 1'b0;
                  phase_in = clcd_pkg::PH_MID_GAP;
               end
               clcd_pkg::PH_MID_GAP: begin
                  nib_in   = held_byte_ff[3:0];
                  en_in    = 1'b1;
                  phase_in = clcd_pkg::PH_LOW_PULSE;
               end
               clcd_pkg::PH_LOW_PULSE: begin
                  en_in    = 1'b0;
                  phase_in = clcd_pkg::PH_BYTE_WAIT;
               end
               clcd_pkg::PH_BYTE_WAIT: begin
                  if (clear_ff) begin
                     phase_in = clcd_pkg::PH_CLEAR_WAIT;
                  end else begin
                     fin = 1'b1;
                  end
               end
               clcd_pkg::PH_CLEAR_WAIT: begin
                  clear_in = 1'b0;
                  fin      = 1'b1;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end

      // byte done: next init command or back to idle
      if (fin) begin
         if (step_ff >= clcd_pkg::STEP_FIRST_CMD && step_ff < clcd_pkg::STEP_LAST_CMD) begin
            step_in = step_ff + 4'd1;
            go_byte = 1'b1;
            go_b    = clcd_pkg::init_cmd(2'(step_ff - 4'd3));
            go_sel  = 1'b0;
         end else begin
            if (step_ff == clcd_pkg::STEP_LAST_CMD) begin
               step_in = clcd_pkg::STEP_DONE;
            end
            phase_in = clcd_pkg::PH_IDLE;
            cnt_in   = '0;
         end
      end

      // start a byte with its high nibble
      if (go_byte) begin
         held_byte_in = go_b;
         held_sel_in  = go_sel;
         rs_in        = go_sel;
         nib_in       = go_b[7:4];
         en_in        = 1'b1;
         cnt_in       = '0;
         phase_in     = clcd_pkg::PH_HIGH_PULSE;
      end

      ready = (req.mode == clcd_pkg::MODE_WRITE) ? !rej : (phase_in == clcd_pkg::PH_IDLE);
   end

   always_comb begin
      rsp.rs_pin     = rs_in;
      rsp.enable_pin = en_in;
      rsp.bus_nibble = nib_in;
      rsp.ready_res  = ready;
      rsp.rejected   = rej;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= clcd_pkg::PH_POWER;
         step_ff      <= '0;
         cnt_ff       <= '0;
         held_byte_ff <= '0;
         held_sel_ff  <= 1'b0;
         clear_ff     <= 1'b0;
         rs_ff        <= 1'b0;
         en_ff        <= 1'b0;
         nib_ff       <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         held_byte_ff <= held_byte_in;
         held_sel_ff  <= held_sel_in;
         clear_ff     <= clear_in;
         rs_ff        <= rs_in;
         en_ff        <= en_in;
         nib_ff       <= nib_in;
      end
   end

endmodule

// ----- sv/char_lcd_nibble_interface.sv -----
// char_lcd_nibble_interface: 4-bit character lcd bus driver, top level
// path: an accepted request passes the input register, then the result register
// throughput: one request per cycle while rsp_ready takes the results, sequencer state advances once per request
// reset: synchronous, clears the pipeline and restarts the power-up wait with reset timings
// depends on clcd_pkg, clcd_csr, clcd_seq
`timescale 1ns / 1ps

module char_lcd_nibble_interface #(
   parameter int WAIT_COUNTER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  clcd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output clcd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [clcd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [clcd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   clcd_pkg::cfg_type cfg;
   clcd_pkg::req_type req_ff;
   clcd_pkg::rsp_type rsp_ff;
   clcd_pkg::rsp_type step_rsp;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance;

   clcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage handshake: input register moves on when the result register frees
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   clcd_seq #(
      .WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/clcd_checker.sv -----
// clcd_port_checks: port-level checks for char_lcd_nibble_interface, bound to the top level
// depends on clcd_pkg
`timescale 1ns / 1ps

module clcd_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input clcd_pkg::rsp_type rsp_data
);

   logic       last_rs_ff;
   logic       last_en_ff;
   logic [3:0] last_nib_ff;

   // pin levels of the last delivered request
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rs_ff  <= 1'b0;
         last_en_ff  <= 1'b0;
         last_nib_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_rs_ff  <= rsp_data.rs_pin;
         last_en_ff  <= rsp_data.enable_pin;
         last_nib_ff <= rsp_data.bus_nibble;
      end
   end

   // a rejected write never reports ready
   a_reject_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> !rsp_data.ready_res)
      else $error("rejected request reported ready");

   // a rejected write leaves the bus pins as they were
   a_reject_keeps_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |->
         rsp_data.rs_pin == last_rs_ff && rsp_data.enable_pin == last_en_ff &&
         rsp_data.bus_nibble == last_nib_ff)
      else $error("rejected request changed the bus pins");

   // with no result waiting the block takes a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind char_lcd_nibble_interface clcd_port_checks u_clcd_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- verif/clcd_checker.sv -----
// clcd_checker: watches the request, result and register ports of the lcd nibble interface
// keeps its own timing copy and sequencer state, predicts pin levels per request, compares
// depends on clcd_pkg
`timescale 1ns / 1ps

module clcd_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  clcd_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  clcd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [clcd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [clcd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   localparam logic [3:0] STEP_FIRST_NIBBLE = 4'd0;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;
   // command bytes sent after the wake nibbles, element 0 goes first
   localparam logic [3:0][7:0] BOOT_CMDS =
      {clcd_pkg::CMD_ENTRY_MODE, clcd_pkg::CMD_CLEAR, clcd_pkg::CMD_DISPLAY_ON,
       clcd_pkg::CMD_FUNCTION_SET};

   // sequencer copy
   clcd_pkg::phase_type lcd_phase;
   logic [3:0]  boot_step;
   logic [15:0] tick_count;
   logic [7:0]  held_byte;
   logic        held_sel;
   logic        clear_owed;
   logic        pin_rs;
   logic        pin_en;
   logic [3:0]  pin_nibble;
   clcd_pkg::cfg_type timing;

   // pin levels expected, oldest first
   clcd_pkg::rsp_type pin_levels_due[$];

   initial begin
      mismatch_count = 0;
      pending_count = 0;
   end

   // counter saturates at its top, a zero target still takes one tick
   function automatic logic timer_hit(input logic [15:0] target);
      if (tick_count != COUNT_TOP)
         tick_count = tick_count + 16'd1;
      if (tick_count >= target) begin
         tick_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void raise_boot_nibble();
      pin_rs = 1'b0;
      pin_nibble = (boot_step == clcd_pkg::STEP_LAST_NIBBLE) ? clcd_pkg::NIB_FOUR_BIT
                                                             : clcd_pkg::NIB_WAKE;
      pin_en = 1'b1;
      tick_count = '0;
      lcd_phase = clcd_pkg::PH_INIT_PULSE;
   endfunction

   function automatic void raise_byte(input logic [7:0] b, input logic sel);
      held_byte = b;
      held_sel = sel;
      pin_rs = sel;
      pin_nibble = b[7:4];
      pin_en = 1'b1;
      tick_count = '0;
      lcd_phase = clcd_pkg::PH_HIGH_PULSE;
   endfunction

   // byte done: next boot command or back to idle
   function automatic void close_byte();
      logic [1:0] cmd_idx;
      if (boot_step >= clcd_pkg::STEP_FIRST_CMD && boot_step < clcd_pkg::STEP_LAST_CMD) begin
         boot_step = boot_step + 4'd1;
         cmd_idx = 2'(boot_step - clcd_pkg::STEP_FIRST_CMD);
         raise_byte(BOOT_CMDS[cmd_idx], 1'b0);
      end else begin
         if (boot_step == clcd_pkg::STEP_LAST_CMD)
            boot_step = clcd_pkg::STEP_DONE;
         lcd_phase = clcd_pkg::PH_IDLE;
         tick_count = '0;
      end
   endfunction

   // one microsecond passes
   function automatic void advance_tick();
      case (lcd_phase)
         clcd_pkg::PH_POWER: begin
            if (timer_hit(timing.power_up_wait)) begin
               boot_step = STEP_FIRST_NIBBLE;
               raise_boot_nibble();
            end
         end
         clcd_pkg::PH_INIT_PULSE: begin
            if (timer_hit(timing.enable_pulse_ticks)) begin
               pin_en = 1'b0;
               lcd_phase = clcd_pkg::PH_INIT_WAIT;
            end
         end
         clcd_pkg::PH_INIT_WAIT: begin
            if (timer_hit((boot_step == STEP_FIRST_NIBBLE) ? timing.first_nibble_wait
                                                           : timing.nibble_gap_wait)) begin
               boot_step = boot_step + 4'd1;
               if (boot_step <= clcd_pkg::STEP_LAST_NIBBLE)
                  raise_boot_nibble();
               else
                  raise_byte(clcd_pkg::CMD_FUNCTION_SET, 1'b0);
            end
         end
         clcd_pkg::PH_HIGH_PULSE: begin
            if (timer_hit(timing.enable_pulse_ticks)) begin
               pin_en = 1'b0;
               lcd_phase = clcd_pkg::PH_MID_GAP;
            end
         end
         clcd_pkg::PH_MID_GAP: begin
            if (timer_hit(timing.nibble_gap_wait)) begin
               pin_nibble = held_byte[3:0];
               pin_en = 1'b1;
               lcd_phase = clcd_pkg::PH_LOW_PULSE;
            end
         end
         clcd_pkg::PH_LOW_PULSE: begin
            if (timer_hit(timing.enable_pulse_ticks)) begin
               pin_en = 1'b0;
               lcd_phase = clcd_pkg::PH_BYTE_WAIT;
            end
         end
         clcd_pkg::PH_BYTE_WAIT: begin
            if (timer_hit(held_sel ? timing.data_wait : timing.command_wait)) begin
               if (clear_owed)
                  lcd_phase = clcd_pkg::PH_CLEAR_WAIT;
               else
                  close_byte();
            end
         end
         clcd_pkg::PH_CLEAR_WAIT: begin
            if (timer_hit(timing.clear_extra_wait)) begin
               clear_owed = 1'b0;
               close_byte();
            end
         end
         default: ;
      endcase
   endfunction

   // pin levels and flags after one request
   function automatic clcd_pkg::rsp_type predict_pins(input clcd_pkg::req_type r);
      clcd_pkg::rsp_type p;
      p = '0;
      if (r.mode == clcd_pkg::MODE_WRITE) begin
         if (lcd_phase == clcd_pkg::PH_IDLE) begin
            clear_owed = !r.reg_select && (r.data_byte == clcd_pkg::CMD_CLEAR);
            raise_byte(r.data_byte, r.reg_select);
            p.ready_res = 1'b1;
         end else begin
            p.rejected = 1'b1;
         end
      end else begin
         advance_tick();
         p.ready_res = (lcd_phase == clcd_pkg::PH_IDLE);
      end
      p.rs_pin = pin_rs;
      p.enable_pin = pin_en;
      p.bus_nibble = pin_nibble;
      return p;
   endfunction

   function automatic void reset_model();
      timing.power_up_wait = clcd_pkg::RST_POWER_UP_WAIT;
      timing.first_nibble_wait = clcd_pkg::RST_FIRST_NIBBLE_WAIT;
      timing.enable_pulse_ticks = clcd_pkg::RST_ENABLE_PULSE_TICKS;
      timing.nibble_gap_wait = clcd_pkg::RST_NIBBLE_GAP_WAIT;
      timing.command_wait = clcd_pkg::RST_COMMAND_WAIT;
      timing.data_wait = clcd_pkg::RST_DATA_WAIT;
      timing.clear_extra_wait = clcd_pkg::RST_CLEAR_EXTRA_WAIT;
      lcd_phase = clcd_pkg::PH_POWER;
      boot_step = STEP_FIRST_NIBBLE;
      tick_count = '0;
      held_byte = '0;
      held_sel = 1'b0;
      clear_owed = 1'b0;
      pin_rs = 1'b0;
      pin_en = 1'b0;
      pin_nibble = '0;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] seen);
      $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, seen);
      mismatch_count++;
   endtask

   // register writes, request prediction, result compare
   always @(posedge clock) begin
      clcd_pkg::rsp_type want;
      if (reset) begin
         reset_model();
         pin_levels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               clcd_pkg::CSR_POWER_UP_WAIT:      timing.power_up_wait = csr_wdata;
               clcd_pkg::CSR_FIRST_NIBBLE_WAIT:  timing.first_nibble_wait = csr_wdata;
               clcd_pkg::CSR_ENABLE_PULSE_TICKS: timing.enable_pulse_ticks = csr_wdata;
               clcd_pkg::CSR_NIBBLE_GAP_WAIT:    timing.nibble_gap_wait = csr_wdata;
               clcd_pkg::CSR_COMMAND_WAIT:       timing.command_wait = csr_wdata;
               clcd_pkg::CSR_DATA_WAIT:          timing.data_wait = csr_wdata;
               clcd_pkg::CSR_CLEAR_EXTRA_WAIT:   timing.clear_extra_wait = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pin_levels_due.push_back(predict_pins(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pin_levels_due.size() == 0) begin
               report_mismatch("result with nothing pending", 8'h00, 8'(rsp_data));
            end else begin
               want = pin_levels_due.pop_front();
               if (rsp_data.rs_pin !== want.rs_pin)
                  report_mismatch("rs_pin", 8'(want.rs_pin), 8'(rsp_data.rs_pin));
               if (rsp_data.enable_pin !== want.enable_pin)
                  report_mismatch("enable_pin", 8'(want.enable_pin), 8'(rsp_data.enable_pin));
               if (rsp_data.bus_nibble !== want.bus_nibble)
                  report_mismatch("bus_nibble", 8'(want.bus_nibble), 8'(rsp_data.bus_nibble));
               if (rsp_data.ready_res !== want.ready_res)
                  report_mismatch("ready_res", 8'(want.ready_res), 8'(rsp_data.ready_res));
               if (rsp_data.rejected !== want.rejected)
                  report_mismatch("rejected", 8'(want.rejected), 8'(rsp_data.rejected));
            end
         end
      end
      pending_count = pin_levels_due.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// tb_top: stimulus, clock, reset and verdict for char_lcd_nibble_interface
// drives tick and write requests and timing registers; checking lives in clcd_checker
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [clcd_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic [clcd_pkg::CSR_DATA_BITS-1:0] WAIT_MAX = 16'hFFFF;
   localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   clcd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   clcd_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [clcd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [clcd_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   clcd_pkg::cfg_type timing;

   char_lcd_nibble_interface u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   clcd_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // result side: random stalls, plus one long hold-off on demand
   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // a zero wait still lasts one tick
   function automatic int span(input logic [clcd_pkg::CSR_DATA_BITS-1:0] t);
      return (t == '0) ? 1 : int'(t);
   endfunction

   // ticks from an accepted write until the block is idle again
   function automatic int byte_ticks(input logic sel, input logic [7:0] b);
      int n;
      n = 2 * span(timing.enable_pulse_ticks) + span(timing.nibble_gap_wait)
          + span(sel ? timing.data_wait : timing.command_wait);
      if (!sel && b == clcd_pkg::CMD_CLEAR)
         n += span(timing.clear_extra_wait);
      return n;
   endfunction

   function automatic clcd_pkg::cfg_type uniform_timing(
         input logic [clcd_pkg::CSR_DATA_BITS-1:0] waits,
         input logic [clcd_pkg::CSR_DATA_BITS-1:0] pulse);
      clcd_pkg::cfg_type c;
      c.power_up_wait = waits;
      c.first_nibble_wait = waits;
      c.enable_pulse_ticks = pulse;
      c.nibble_gap_wait = waits;
      c.command_wait = waits;
      c.data_wait = waits;
      c.clear_extra_wait = waits;
      return c;
   endfunction

   function automatic clcd_pkg::cfg_type random_timing(input int max_wait);
      clcd_pkg::cfg_type c;
      c.power_up_wait = 16'($urandom_range(0, max_wait));
      c.first_nibble_wait = 16'($urandom_range(0, max_wait));
      c.enable_pulse_ticks = 16'($urandom_range(1, max_wait));
      c.nibble_gap_wait = 16'($urandom_range(0, max_wait));
      c.command_wait = 16'($urandom_range(0, max_wait));
      c.data_wait = 16'($urandom_range(0, max_wait));
      c.clear_extra_wait = 16'($urandom_range(0, max_wait));
      return c;
   endfunction

   task automatic write_reg(input logic [clcd_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [clcd_pkg::CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // all timing registers, plus the unused index which must be ignored
   task automatic apply_timing(input clcd_pkg::cfg_type c);
      timing = c;
      write_reg(clcd_pkg::CSR_POWER_UP_WAIT, c.power_up_wait);
      write_reg(clcd_pkg::CSR_FIRST_NIBBLE_WAIT, c.first_nibble_wait);
      write_reg(clcd_pkg::CSR_ENABLE_PULSE_TICKS, c.enable_pulse_ticks);
      write_reg(clcd_pkg::CSR_NIBBLE_GAP_WAIT, c.nibble_gap_wait);
      write_reg(clcd_pkg::CSR_COMMAND_WAIT, c.command_wait);
      write_reg(clcd_pkg::CSR_DATA_WAIT, c.data_wait);
      write_reg(clcd_pkg::CSR_CLEAR_EXTRA_WAIT, c.clear_extra_wait);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
   endtask

   // one request, held until accepted; returns at a falling edge
   task automatic send_req(input logic mode, input logic sel, input logic [7:0] b);
      clcd_pkg::req_type r;
      r.mode = mode;
      r.reg_select = sel;
      r.data_byte = b;
      // idle cycles, each taken with the sender's idle odds
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_req(clcd_pkg::MODE_TICK, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
   endtask

   task automatic send_byte(input logic sel, input logic [7:0] b);
      send_req(clcd_pkg::MODE_WRITE, sel, b);
      send_ticks(byte_ticks(sel, b));
   endtask

   // sender pauses until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4) @(negedge clock);
   endtask

   // mostly whole writes with the ticks they need, some cut short, some noise
   task automatic run_mix(input int n_items);
      int done;
      int n;
      logic sel;
      logic [7:0] b;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(0, 99) < 20) begin
            send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
            done++;
         end else begin
            sel = 1'($urandom_range(0, 1));
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
               sel = 1'b0;
               b = clcd_pkg::CMD_CLEAR;
            end
            n = byte_ticks(sel, b);
            if ($urandom_range(0, 99) < 25)
               n = $urandom_range(0, n - 1);
            else
               n = n + $urandom_range(0, 2);
            send_req(clcd_pkg::MODE_WRITE, sel, b);
            send_ticks(n);
            done += n + 1;
         end
      end
   endtask

   initial begin
      int n;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shortest timings, boot sequence with writes refused while busy
      apply_timing(uniform_timing('0, 16'd1));
      send_req(clcd_pkg::MODE_WRITE, 1'b1, 8'hFF);
      n = span(timing.power_up_wait) + span(timing.first_nibble_wait)
          + 4 * span(timing.enable_pulse_ticks) + 3 * span(timing.nibble_gap_wait)
          + 4 * (2 * span(timing.enable_pulse_ticks) + span(timing.nibble_gap_wait)
                 + span(timing.command_wait));
      send_ticks(n - 1);
      send_req(clcd_pkg::MODE_WRITE, 1'b0, 8'h00);
      send_ticks(1);

      // clear, data extremes, address and display commands, write one tick too early
      send_byte(1'b0, clcd_pkg::CMD_CLEAR);
      send_byte(1'b1, 8'hFF);
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, CMD_SET_ADDRESS);
      send_byte(1'b0, CMD_DISPLAY_OFF);
      send_req(clcd_pkg::MODE_WRITE, 1'b1, 8'hA5);
      send_ticks(byte_ticks(1'b1, 8'hA5) - 1);
      send_req(clcd_pkg::MODE_WRITE, 1'b0, 8'h5A);
      send_ticks(1);
      send_byte(1'b0, 8'h5A);

      // sender idles less than receiver, with one long receiver hold-off
      wait_drained();
      tx_idle_pct = 38;
      rx_idle_pct = 59;
      apply_timing(random_timing(3));
      hold_seq++;
      run_mix(670);

      // receiver idles less than sender, with a full drain halfway
      wait_drained();
      tx_idle_pct = 59;
      rx_idle_pct = 38;
      apply_timing(random_timing(8));
      run_mix(335);
      wait_drained();
      run_mix(335);

      // back to back
      wait_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      apply_timing(random_timing(2));
      run_mix(670);
      send_ticks(64);

      // longest waits with the shortest pulse, first steps of an external clear
      wait_drained();
      apply_timing(uniform_timing(WAIT_MAX, 16'd1));
      send_req(clcd_pkg::MODE_WRITE, 1'b0, clcd_pkg::CMD_CLEAR);
      send_ticks(16);

      // longest pulse with the shortest waits, taken up mid byte, write refused
      wait_drained();
      apply_timing(uniform_timing('0, WAIT_MAX));
      send_req(clcd_pkg::MODE_WRITE, 1'b1, 8'($urandom_range(0, 255)));
      send_ticks(16);

      wait_drained();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/clcd_pkg.sv
sv/clcd_csr.sv
sv/clcd_seq.sv
sv/char_lcd_nibble_interface.sv
sv/clcd_checker.sv
verif/clcd_checker.sv
verif/tb_top.sv
